// File: sv/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg: shared types and constants of the midpoint ellipse rasterizer
// Coordinate widths, register map, opcodes and the point status record.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

   localparam int COORD_BITS = 10;
   localparam int PIX_BITS   = 12;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COORD_BITS-1:0] CENTER_RESET = 10'd300;

   // word index inside the register window (paddr[2])
   localparam logic REG_CENTER_X = 1'b0;
   localparam logic REG_CENTER_Y = 1'b1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // point being presented by the core
   typedef struct packed {
      logic       valid;
      logic [1:0] idx;    // bit 0: mirror x, bit 1: mirror y
      logic       fin;
   } emit_type;

endpackage

`default_nettype wire

// File: sv/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: two-region midpoint ellipse point generator
// A start item loads the radii, each step item yields the next point; every
// point leaves as four mirrored pixels about the configured center.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   op, radius_x, radius_y
//   rsp      out        rsp_valid / rsp_stall   pixel_x, pixel_y, last, done_res
//   csr      in         APB write/read          center_x (0x0), center_y (0x4)
//
// A start runs its setup (squares and 2*rx^2*ry on the shared multiplier) in
// ST_SQX..ST_CHOOSE, plus ST_R2A..ST_R2E when it lands straight in region 2.
// A step passes ST_STEPA and ST_STEPB, and ST_CHOOSE too in region 1, plus
// ST_R2A..ST_R2E on the step into region 2; each product is registered.
// Then the four mirrored pixels leave in turn, as rsp_stall allows.
// req_stall stays high from acceptance until the fourth pixel is taken.
// A step after the final group is taken and yields nothing.
// Reset is synchronous; the center returns to (300, 300).
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer #(
   parameter int RADIUS_BITS = 9
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_op,
   input  wire logic [RADIUS_BITS-1:0]             req_radius_x,
   input  wire logic [RADIUS_BITS-1:0]             req_radius_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mer_pkg::PIX_BITS-1:0]     rsp_pixel_x,
   output logic signed [mer_pkg::PIX_BITS-1:0]     rsp_pixel_y,
   output logic                                    rsp_last,
   output logic                                    rsp_done_res,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mer_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [mer_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [mer_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready
);

   import mer_pkg::*;

   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   emit_type               emit;
   logic [RADIUS_BITS:0]   offset_x;
   logic [RADIUS_BITS:0]   offset_y;
   logic                   rsp_take;
   logic [PIX_BITS-1:0]    cx_ext, cy_ext, ox_ext, oy_ext;

   mer_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .center_x   (center_x),
      .center_y   (center_y)
   );

   mer_core #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_op      (req_op),
      .req_radius_x(req_radius_x),
      .req_radius_y(req_radius_y),
      .req_stall   (req_stall),
      .rsp_take    (rsp_take),
      .emit        (emit),
      .offset_x    (offset_x),
      .offset_y    (offset_y)
   );

   assign rsp_take = rsp_valid & ~rsp_stall;

   // coordinates wrap to the pixel width
   assign cx_ext = PIX_BITS'(center_x);
   assign cy_ext = PIX_BITS'(center_y);
   assign ox_ext = PIX_BITS'(offset_x);
   assign oy_ext = PIX_BITS'(offset_y);

   assign rsp_valid    = emit.valid;
   assign rsp_pixel_x  = signed'(emit.idx[0] ? cx_ext - ox_ext : cx_ext + ox_ext);
   assign rsp_pixel_y  = signed'(emit.idx[1] ? cy_ext - oy_ext : cy_ext + oy_ext);
   assign rsp_last     = (emit.idx == 2'd3);
   assign rsp_done_res = emit.fin;

endmodule

`default_nettype wire

// File: sv/mer_mult.sv
// ----------------------------------------------------------------------------
// mer_mult: shared unsigned multiplier
// One product per cycle, result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_mult #(
   parameter int A_BITS = 29,
   parameter int B_BITS = 18
) (
   input  wire logic                     clock,
   input  wire logic [A_BITS-1:0]        mul_a,
   input  wire logic [B_BITS-1:0]        mul_b,
   output logic      [A_BITS+B_BITS-1:0] prod_ff
);

   localparam int P_BITS = A_BITS + B_BITS;

   logic [P_BITS-1:0] prod_in;

   assign prod_in = P_BITS'(mul_a) * P_BITS'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// File: sv/mer_csr.sv
// ----------------------------------------------------------------------------
// mer_csr: center coordinate registers
// APB-style write and read of the ellipse center.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mer_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [mer_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [mer_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready,
   output logic      [mer_pkg::COORD_BITS-1:0]     center_x,
   output logic      [mer_pkg::COORD_BITS-1:0]     center_y
);

   import mer_pkg::*;

   logic [COORD_BITS-1:0] cx_ff, cx_in;
   logic [COORD_BITS-1:0] cy_ff, cy_in;
   logic                  wr_en;
   logic                  reg_sel;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel = csr_paddr[2];

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_CENTER_X: cx_in = csr_pwdata[COORD_BITS-1:0];
            REG_CENTER_Y: cy_in = csr_pwdata[COORD_BITS-1:0];
            default:      cx_in = cx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= CENTER_RESET;
         cy_ff <= CENTER_RESET;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CENTER_X: csr_prdata = CSR_DATA_BITS'(cx_ff);
         REG_CENTER_Y: csr_prdata = CSR_DATA_BITS'(cy_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign center_x   = cx_ff;
   assign center_y   = cy_ff;

endmodule

`default_nettype wire

// File: sv/mer_core.sv
// ----------------------------------------------------------------------------
// mer_core: midpoint ellipse sequencer and datapath
// Walks region 1 and region 2 one point per step; squares and region 2
// setup products run through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_core #(
   parameter int RADIUS_BITS = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_op,
   input  wire logic [RADIUS_BITS-1:0] req_radius_x,
   input  wire logic [RADIUS_BITS-1:0] req_radius_y,
   output logic                        req_stall,
   input  wire logic                   rsp_take,
   output mer_pkg::emit_type           emit,
   output logic      [RADIUS_BITS:0]   offset_x,
   output logic      [RADIUS_BITS:0]   offset_y
);

   import mer_pkg::*;

   localparam int R  = RADIUS_BITS;
   localparam int OW = R + 1;          // offsets
   localparam int QW = 2 * R;          // squared radii
   localparam int SW = 3 * R + 3;      // slope terms
   localparam int DW = 5 * R + 3;      // decision, scaled by 4
   localparam int MA = 3 * R + 2;      // multiplier operand a
   localparam int MB = 2 * R;          // multiplier operand b
   localparam int PW = MA + MB;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_SQX    = 14'b00000000000010,
      ST_SQY    = 14'b00000000000100,
      ST_RXRY   = 14'b00000000001000,
      ST_INIT   = 14'b00000000010000,
      ST_CHOOSE = 14'b00000000100000,
      ST_R2A    = 14'b00000001000000,
      ST_R2B    = 14'b00000010000000,
      ST_R2C    = 14'b00000100000000,
      ST_R2D    = 14'b00001000000000,
      ST_R2E    = 14'b00010000000000,
      ST_STEPA  = 14'b00100000000000,
      ST_STEPB  = 14'b01000000000000,
      ST_EMIT   = 14'b10000000000000
   } state_type;

   typedef enum logic [1:0] {
      RGN_IDLE = 2'd0,
      RGN_ONE  = 2'd1,
      RGN_TWO  = 2'd2
   } region_type;

   state_type         state_ff, state_in;
   region_type        region_ff, region_in;
   logic [1:0]        idx_ff, idx_in;
   logic              fin_ff, fin_in;
   logic              diag_ff, diag_in;
   logic [R-1:0]      rx_ff, rx_in;
   logic [R-1:0]      ry_ff, ry_in;
   logic [QW-1:0]     rxsq_ff, rxsq_in;
   logic [QW-1:0]     rysq_ff, rysq_in;
   logic [OW-1:0]     ox_ff, ox_in;
   logic [OW-1:0]     oy_ff, oy_in;
   logic [SW-1:0]     sx_ff, sx_in;
   logic [SW-1:0]     sy_ff, sy_in;
   logic signed [DW-1:0] dec_ff, dec_in;

   logic [MA-1:0]     mul_a;
   logic [MB-1:0]     mul_b;
   logic [PW-1:0]     prod_ff;

   logic [SW-1:0]     rxsq2;
   logic [SW-1:0]     rysq2;
   logic [OW:0]       tx;
   logic [OW-1:0]     ty;
   logic signed [DW-1:0] rxsq_s, rysq_s, sx_s, sy_s, prod_s, term;
   logic              dec_neg, dec_pos;

   mer_mult #(
      .A_BITS(MA),
      .B_BITS(MB)
   ) u_mult (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   assign rxsq2   = SW'({rxsq_ff, 1'b0});
   assign rysq2   = SW'({rysq_ff, 1'b0});
   assign tx      = {ox_ff, 1'b1};
   assign ty      = oy_ff - OW'(1);
   assign rxsq_s  = signed'(DW'(rxsq_ff));
   assign rysq_s  = signed'(DW'(rysq_ff));
   assign sx_s    = signed'(DW'(sx_ff));
   assign sy_s    = signed'(DW'(sy_ff));
   assign prod_s  = signed'(DW'(prod_ff));
   assign dec_neg = dec_ff[DW-1];
   assign dec_pos = !dec_ff[DW-1] && (dec_ff != '0);

   // region 1 adds ry^2 + sx (- sy on a diagonal move);
   // region 2 adds rx^2 - sy (+ sx on a diagonal move)
   always_comb begin
      if (region_ff == RGN_ONE) begin
         term = rysq_s + sx_s - (diag_ff ? sy_s : '0);
      end else begin
         term = rxsq_s - sy_s + (diag_ff ? sx_s : '0);
      end
   end

   always_comb begin
      state_in  = state_ff;
      region_in = region_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      diag_in   = diag_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rxsq_in   = rxsq_ff;
      rysq_in   = rysq_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      dec_in    = dec_ff;
      mul_a     = '0;
      mul_b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_START) begin
                  rx_in    = req_radius_x;
                  ry_in    = req_radius_y;
                  state_in = ST_SQX;
               end else if (region_ff != RGN_IDLE) begin
                  state_in = ST_STEPA;
               end
            end
         end
         ST_SQX: begin
            mul_a    = MA'(rx_ff);
            mul_b    = MB'(rx_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rxsq_in  = prod_ff[QW-1:0];
            mul_a    = MA'(ry_ff);
            mul_b    = MB'(ry_ff);
            state_in = ST_RXRY;
         end
         ST_RXRY: begin
            rysq_in  = prod_ff[QW-1:0];
            mul_a    = MA'(rxsq_ff);
            mul_b    = MB'(ry_ff);
            ox_in    = '0;
            oy_in    = OW'(ry_ff);
            sx_in    = '0;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            // product is rx^2 * ry
            sy_in    = SW'({prod_ff[3*R-1:0], 1'b0});
            dec_in   = (rysq_s <<< 2) - (signed'(DW'(prod_ff[3*R-1:0])) <<< 2) + rxsq_s;
            state_in = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            if (sx_ff < sy_ff) begin
               region_in = RGN_ONE;
               fin_in    = 1'b0;
               state_in  = ST_EMIT;
            end else if (oy_ff != '0) begin
               mul_a    = MA'(rysq_ff);
               mul_b    = MB'(tx);
               state_in = ST_R2A;
            end else begin
               region_in = RGN_IDLE;
               fin_in    = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_R2A: begin
            mul_a    = prod_ff[MA-1:0];
            mul_b    = MB'(tx);
            state_in = ST_R2B;
         end
         ST_R2B: begin
            dec_in   = prod_s;
            mul_a    = MA'(rxsq_ff);
            mul_b    = MB'(ty);
            state_in = ST_R2C;
         end
         ST_R2C: begin
            mul_a    = prod_ff[MA-1:0];
            mul_b    = MB'(ty);
            state_in = ST_R2D;
         end
         ST_R2D: begin
            dec_in   = dec_ff + (prod_s <<< 2);
            mul_a    = MA'(rxsq_ff);
            mul_b    = MB'(rysq_ff);
            state_in = ST_R2E;
         end
         ST_R2E: begin
            dec_in    = dec_ff - (prod_s <<< 2);
            region_in = RGN_TWO;
            fin_in    = 1'b0;
            state_in  = ST_EMIT;
         end
         ST_STEPA: begin
            if (region_ff == RGN_ONE) begin
               ox_in   = ox_ff + OW'(1);
               sx_in   = sx_ff + rysq2;
               diag_in = !dec_neg;
               if (!dec_neg) begin
                  oy_in = oy_ff - OW'(1);
                  sy_in = sy_ff - rxsq2;
               end
            end else begin
               oy_in   = oy_ff - OW'(1);
               sy_in   = sy_ff - rxsq2;
               diag_in = !dec_pos;
               if (!dec_pos) begin
                  ox_in = ox_ff + OW'(1);
                  sx_in = sx_ff + rysq2;
               end
            end
            state_in = ST_STEPB;
         end
         ST_STEPB: begin
            dec_in = dec_ff + (term <<< 2);
            if (region_ff == RGN_ONE) begin
               state_in = ST_CHOOSE;
            end else begin
               fin_in    = (oy_ff == '0);
               region_in = (oy_ff == '0) ? RGN_IDLE : RGN_TWO;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         region_ff <= RGN_IDLE;
         idx_ff    <= 2'd0;
      end else begin
         state_ff  <= state_in;
         region_ff <= region_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff  <= fin_in;
      diag_ff <= diag_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rxsq_ff <= rxsq_in;
      rysq_ff <= rysq_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      dec_ff  <= dec_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign emit.valid = (state_ff == ST_EMIT);
   assign emit.idx   = idx_ff;
   assign emit.fin   = fin_ff;
   assign offset_x   = ox_ff;
   assign offset_y   = oy_ff;

endmodule

`default_nettype wire

// File: sv/mer_checker.sv
// ----------------------------------------------------------------------------
// mer_checker: port-level checks of the ellipse rasterizer
// Group framing and input blocking as seen on the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               req_op,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic signed [mer_pkg::PIX_BITS-1:0] rsp_pixel_x,
   input wire logic signed [mer_pkg::PIX_BITS-1:0] rsp_pixel_y,
   input wire logic                               rsp_last,
   input wire logic                               rsp_done_res
);

   import mer_pkg::*;

   // a start item always blocks the input for its setup
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == OP_START) |=> req_stall)
      else $error("input not blocked after a start item");

   // no new item while pixels are pending
   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a group is pending");

   // a group ends on its last pixel, and not before
   a_group_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid)
      else $error("pixel output continued past the last pixel");

   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> (rsp_valid && $stable(rsp_done_res)))
      else $error("group cut short or done flag changed inside a group");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)))
      else $error("stalled pixel changed");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .rsp_last    (rsp_last),
   .rsp_done_res(rsp_done_res)
);

`default_nettype wire
